// File: rtl/ffa_pkg.sv
// Shared types, codes and constants of the first-fit block allocator.
package ffa_pkg;

  // Address and limit widths are fixed by the request and result fields
  localparam int ADDR_W   = 20;
  localparam int LIMIT_W  = 21;
  localparam int STATUS_W = 3;

  // Heap limit after reset: the whole address space
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1) << ADDR_W;
  localparam logic [LIMIT_W-1:0] ADDR_SPACE  = LIMIT_W'(1) << ADDR_W;

  // Sizes are rounded up to a multiple of eight
  localparam logic [LIMIT_W-1:0] ROUND_ADD  = LIMIT_W'(7);
  localparam logic [LIMIT_W-1:0] ROUND_MASK = ~LIMIT_W'(7);

  // Request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_ZERO_SIZE  = 3'd1,
    ST_HEAP_FULL  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_t;

  // Request beat
  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } req_beat_t;

  // Result beat
  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [STATUS_W-1:0] status;
  } rsp_beat_t;

  // Datapath actions, one per cycle
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_ZERO,
    ACT_NULL_FREE,
    ACT_REUSE,
    ACT_TABLE_FULL,
    ACT_HEAP_FULL,
    ACT_APPEND,
    ACT_NOT_FOUND,
    ACT_MARK,
    ACT_MERGE,
    ACT_FLUSH
  } act_t;

  // Controller to datapath
  typedef struct packed {
    act_t act;
    logic scan;   // issue the next table read
    logic emit;   // move the finished result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op;
    logic size_zero;
    logic where_null;
    logic rd_vld;
    logic scan_end;
    logic hit_alloc;
    logic hit_free;
    logic table_full;
    logic heap_fail;
  } sts_t;

endpackage

// File: rtl/ffa_ctrl.sv
// Controller state machine of the first-fit block allocator.
module ffa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  ffa_pkg::sts_t sts,
  output ffa_pkg::cmd_t cmd
);
  import ffa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_FIND,
    S_MERGE,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  // Command and next-state decode
  always_comb begin
    cmd        = '{act: ACT_NONE, scan: 1'b0, emit: 1'b0};
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.act    = ACT_LOAD;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.op == OP_ALLOC && sts.size_zero) begin
          cmd.act    = ACT_ZERO;
          state_next = S_DONE;
        end else if (sts.op == OP_FREE && sts.where_null) begin
          cmd.act    = ACT_NULL_FREE;
          state_next = S_DONE;
        end else begin
          cmd.scan   = 1'b1;
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        if (sts.rd_vld && sts.op == OP_ALLOC && sts.hit_alloc) begin
          cmd.act    = ACT_REUSE;
          state_next = S_DONE;
        end else if (sts.rd_vld && sts.op == OP_FREE && sts.hit_free) begin
          cmd.act    = ACT_MARK;
          state_next = S_MERGE;
        end else if (!sts.rd_vld && sts.scan_end) begin
          // whole table seen without a hit
          if (sts.op == OP_FREE) begin
            cmd.act = ACT_NOT_FOUND;
          end else if (sts.table_full) begin
            cmd.act = ACT_TABLE_FULL;
          end else if (sts.heap_fail) begin
            cmd.act = ACT_HEAP_FULL;
          end else begin
            cmd.act = ACT_APPEND;
          end
          state_next = S_DONE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_MERGE: begin
        if (!sts.rd_vld && sts.scan_end) begin
          cmd.act    = ACT_FLUSH;
          state_next = S_DONE;
        end else begin
          cmd.act  = ACT_MERGE;
          cmd.scan = 1'b1;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result-valid register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/ffa_dp.sv
// Datapath of the first-fit block allocator: block table, pointers, result.
module ffa_dp #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ffa_pkg::req_beat_t            req,
  output ffa_pkg::rsp_beat_t            rsp,
  input  logic                          cfg_wr_en,
  input  logic [ffa_pkg::LIMIT_W-1:0]   cfg_wr_data,
  input  ffa_pkg::cmd_t                 cmd,
  output ffa_pkg::sts_t                 sts
);
  import ffa_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(MAX_BLOCKS);
  localparam logic [ADDR_W-1:0]  HDR_A   = ADDR_W'(HEADER_BYTES);
  localparam logic [LIMIT_W-1:0] HDR_L   = LIMIT_W'(HEADER_BYTES);
  localparam logic [LIMIT_W:0]   HDR_T   = (LIMIT_W + 1)'(HEADER_BYTES);

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] bytes;
    logic              free;
  } entry_t;

  // Block table
  entry_t mem [MAX_BLOCKS];

  // Request and allocator state
  req_beat_t          cur;
  logic [LIMIT_W-1:0] need;
  logic [CNT_W-1:0]   count;
  logic [LIMIT_W-1:0] heap_top;
  logic [LIMIT_W-1:0] heap_limit;

  // Scan and compaction state
  logic [CNT_W-1:0] rd_ptr;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_vld;
  entry_t           rdata;
  logic [IDX_W-1:0] match_idx;
  logic [IDX_W-1:0] wr_ptr;
  entry_t           hold;
  logic             hold_vld;

  rsp_beat_t res;

  // Derived values
  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W:0]   top_after;
  logic               rd_more;
  entry_t             cur_e;
  logic               mergeable;
  logic [IDX_W-1:0]   merge_from;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  assign limit      = (heap_limit > ADDR_SPACE) ? ADDR_SPACE : heap_limit;
  assign top_after  = {1'b0, heap_top} + HDR_T + {1'b0, need};
  assign rd_more    = (rd_ptr < count);
  assign merge_from = (rd_idx == '0) ? '0 : rd_idx - IDX_W'(1);

  // Entry under compaction, with the freed block marked
  always_comb begin
    cur_e      = rdata;
    cur_e.free = rdata.free | (rd_idx == match_idx);
  end
  assign mergeable = hold_vld && hold.free && cur_e.free;

  // Status to the controller
  always_comb begin
    sts.op         = cur.op;
    sts.size_zero  = (cur.request_size == '0);
    sts.where_null = (cur.block_address == '0);
    sts.rd_vld     = rd_vld;
    sts.scan_end   = !rd_more;
    sts.hit_alloc  = rdata.free && ({1'b0, rdata.bytes} >= need);
    sts.hit_free   = (({1'b0, rdata.start} + HDR_L) == {1'b0, cur.block_address});
    sts.table_full = (count >= CNT_MAX);
    sts.heap_fail  = (top_after > {1'b0, limit});
  end

  // Single table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = rdata;
    case (cmd.act)
      ACT_REUSE: begin
        wr_en        = 1'b1;
        wr_data.free = 1'b0;
      end
      ACT_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = count[IDX_W-1:0];
        wr_data = '{start: heap_top[ADDR_W-1:0], bytes: need[ADDR_W-1:0], free: 1'b0};
      end
      ACT_MERGE: begin
        wr_en   = rd_vld && hold_vld && !mergeable;
        wr_addr = wr_ptr;
        wr_data = hold;
      end
      ACT_FLUSH: begin
        wr_en   = 1'b1;
        wr_addr = wr_ptr;
        wr_data = hold;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Table write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Table read, one entry a cycle while scanning
  always_ff @(posedge clk) begin
    if (cmd.scan && rd_more) begin
      rdata  <= mem[rd_ptr[IDX_W-1:0]];
      rd_idx <= rd_ptr[IDX_W-1:0];
    end
  end

  // Control registers and result
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      heap_top   <= '0;
      heap_limit <= LIMIT_RESET;
      rd_vld     <= 1'b0;
      rd_ptr     <= '0;
      hold_vld   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        heap_limit <= cfg_wr_data;
      end
      rd_vld <= cmd.scan && rd_more;
      if (cmd.scan && rd_more) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
      end
      case (cmd.act)
        ACT_LOAD: begin
          cur    <= req;
          need   <= (LIMIT_W'(req.request_size) + ROUND_ADD) & ROUND_MASK;
          rd_ptr <= '0;
        end
        ACT_ZERO: begin
          res <= '{address: '0, status: ST_ZERO_SIZE};
        end
        ACT_NULL_FREE: begin
          res <= '{address: '0, status: ST_OK};
        end
        ACT_REUSE: begin
          res <= '{address: rdata.start + HDR_A, status: ST_OK};
        end
        ACT_TABLE_FULL: begin
          res <= '{address: '0, status: ST_TABLE_FULL};
        end
        ACT_HEAP_FULL: begin
          res <= '{address: '0, status: ST_HEAP_FULL};
        end
        ACT_APPEND: begin
          count    <= count + CNT_W'(1);
          heap_top <= top_after[LIMIT_W-1:0];
          res      <= '{address: heap_top[ADDR_W-1:0] + HDR_A, status: ST_OK};
        end
        ACT_NOT_FOUND: begin
          res <= '{address: '0, status: ST_NOT_FOUND};
        end
        ACT_MARK: begin
          // compaction starts at the left neighbour of the freed block, or at the block itself when it is first
          match_idx <= rd_idx;
          rd_ptr    <= CNT_W'(merge_from);
          wr_ptr    <= merge_from;
          hold_vld  <= 1'b0;
        end
        ACT_MERGE: begin
          if (rd_vld) begin
            if (!hold_vld) begin
              hold     <= cur_e;
              hold_vld <= 1'b1;
            end else if (mergeable) begin
              hold.bytes <= hold.bytes + cur_e.bytes + HDR_A;
            end else begin
              hold   <= cur_e;
              wr_ptr <= wr_ptr + IDX_W'(1);
            end
          end
        end
        ACT_FLUSH: begin
          count    <= CNT_W'(wr_ptr) + CNT_W'(1);
          hold_vld <= 1'b0;
          res      <= '{address: '0, status: ST_OK};
        end
        default: begin
          res <= res;
        end
      endcase
      if (cmd.emit) begin
        rsp <= res;
      end
    end
  end

endmodule

// File: rtl/first_fit_block_allocator_top.sv
// An allocate walks the table until a fit or its end; a free walks it to the
// freed block, then again from its left neighbour to merge; one entry a cycle.
// Throughput: one request at a time; the next is accepted the cycle after the
// result enters the output register. The table walk dominates each request.
// Reset (rst, synchronous): block count and bump pointer cleared, heap limit set
// to the full address space; the table itself is not cleared and needs no pass.
module first_fit_block_allocator_top #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  ffa_pkg::req_beat_t          req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output ffa_pkg::rsp_beat_t          rsp,
  input  logic                        cfg_wr_en,
  input  logic [ffa_pkg::LIMIT_W-1:0] cfg_wr_data
);
  import ffa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table and arithmetic
  ffa_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts)
  );

  // A finished result never overwrites a beat still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!rsp_valid || rsp_ready))
    else $error("result overwrote a pending beat");

  // A block is reused only when the entry just read fits
  a_reuse_fits: assert property (@(posedge clk) disable iff (rst)
    (cmd.act == ACT_REUSE) |-> (sts.rd_vld && sts.hit_alloc))
    else $error("reuse without a fitting free block");

  // Appending needs room in both the table and the heap
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.act == ACT_APPEND) |-> (!sts.table_full && !sts.heap_fail))
    else $error("append past table or heap limit");

  // An accepted beat leads to a load and no output emission in that cycle
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |-> (cmd.act == ACT_LOAD && !cmd.emit))
    else $error("accepted beat not loaded");

endmodule

// File: test/tb_first_fit_block_allocator_top.sv
// Self-checking testbench for the first-fit block allocator top level.
`timescale 1ns / 100ps

module tb_first_fit_block_allocator_top;
  import ffa_pkg::*;

  localparam int MAXB           = 64;
  localparam int HDR            = 24;
  localparam int SETTLE_CYCLES  = 160;   // beyond the longest free-with-merge walk
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either channel
  localparam int HOLD_CYCLES    = 700;   // long receiver hold-off
  localparam int REPORT_MAX     = 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  req_beat_t            req = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rsp_beat_t            rsp;
  logic                 cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wr_data = '0;

  first_fit_block_allocator_top #(
    .MAX_BLOCKS  (MAXB),
    .HEADER_BYTES(HDR)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Allocator model: block table in address order, bump pointer, heap limit
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]  tbl_start [MAXB];
  logic [ADDR_W-1:0]  tbl_bytes [MAXB];
  logic               tbl_free  [MAXB];
  int                 tbl_count = 0;
  logic [LIMIT_W-1:0] model_top = '0;
  logic [LIMIT_W-1:0] model_limit = LIMIT_RESET;

  rsp_beat_t pending_results[$];

  int mismatches = 0;
  int n_sent     = 0;
  int n_ok       = 0;
  int n_zero     = 0;
  int n_heap     = 0;
  int n_table    = 0;
  int n_missing  = 0;
  int n_merges   = 0;

  logic hold_req = 1'b0;

  // Fold every run of adjacent free blocks into its first block
  function automatic void merge_free_neighbours();
    int i;
    int k;
    i = 0;
    while (i + 1 < tbl_count) begin
      if (tbl_free[i] && tbl_free[i+1]) begin
        tbl_bytes[i] = ADDR_W'(tbl_bytes[i] + tbl_bytes[i+1] + HDR);
        for (k = i + 1; k + 1 < tbl_count; k++) begin
          tbl_start[k] = tbl_start[k+1];
          tbl_bytes[k] = tbl_bytes[k+1];
          tbl_free[k]  = tbl_free[k+1];
        end
        tbl_count--;
        n_merges++;
      end else begin
        i++;
      end
    end
  endfunction

  // Result of one request; updates the model state
  function automatic rsp_beat_t predict_request(req_beat_t beat);
    rsp_beat_t          res;
    logic [LIMIT_W-1:0] need;
    logic [LIMIT_W-1:0] lim;
    logic [22:0]        top_after;
    int                 i;
    res = '0;
    res.status = ST_OK;
    if (beat.op == OP_ALLOC) begin
      if (beat.request_size == '0) begin
        res.status = ST_ZERO_SIZE;
        return res;
      end
      need = (LIMIT_W'(beat.request_size) + ROUND_ADD) & ROUND_MASK;
      // first fit among free blocks, no split
      for (i = 0; i < tbl_count; i++) begin
        if (tbl_free[i] && LIMIT_W'(tbl_bytes[i]) >= need) begin
          tbl_free[i] = 1'b0;
          res.address = ADDR_W'(tbl_start[i] + HDR);
          return res;
        end
      end
      if (tbl_count >= MAXB) begin
        res.status = ST_TABLE_FULL;
        return res;
      end
      lim = (model_limit > ADDR_SPACE) ? ADDR_SPACE : model_limit;
      top_after = 23'(model_top) + 23'(HDR) + 23'(need);
      if (top_after > 23'(lim)) begin
        res.status = ST_HEAP_FULL;
        return res;
      end
      tbl_start[tbl_count] = model_top[ADDR_W-1:0];
      tbl_bytes[tbl_count] = need[ADDR_W-1:0];
      tbl_free[tbl_count]  = 1'b0;
      tbl_count++;
      res.address = ADDR_W'(model_top + HDR);
      model_top   = top_after[LIMIT_W-1:0];
      return res;
    end
    // free request
    if (beat.block_address == '0) return res;
    for (i = 0; i < tbl_count; i++) begin
      if (LIMIT_W'(tbl_start[i]) + LIMIT_W'(HDR) == LIMIT_W'(beat.block_address)) begin
        tbl_free[i] = 1'b1;
        merge_free_neighbours();
        return res;
      end
    end
    res.status = ST_NOT_FOUND;
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] user_addr(int idx);
    return ADDR_W'(tbl_start[idx] + HDR);
  endfunction

  function automatic req_beat_t make_req(logic op, logic [ADDR_W-1:0] size,
                                         logic [ADDR_W-1:0] where);
    req_beat_t beat;
    beat.op            = op;
    beat.request_size  = size;
    beat.block_address = where;
    return beat;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: one beat at a time, driven on the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_request(input req_beat_t beat);
    @(negedge clk);
    req       <= beat;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_results.push_back(predict_request(beat));
    n_sent++;
  endtask

  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
  endtask

  // Sender pauses until every result is back, then lets the block settle
  task automatic wait_for_drain(input int settle);
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_heap_limit(input logic [LIMIT_W-1:0] value);
    wait_for_drain(SETTLE_CYCLES);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    model_limit = value;
  endtask

  function automatic logic [ADDR_W-1:0] random_size(bit allow_big);
    int roll;
    roll = $urandom_range(0, 99);
    if (allow_big && roll < 8) return ADDR_W'($urandom);
    if (roll < 70) return ADDR_W'($urandom_range(1, 64));
    if (roll < 95) return ADDR_W'($urandom_range(1, 512));
    return ADDR_W'($urandom_range(1, 4096));
  endfunction

  // Mostly well-formed traffic: allocations and frees of live blocks,
  // with double frees, null frees, stray addresses and zero sizes mixed in
  function automatic req_beat_t random_request(bit allow_big);
    int roll;
    int i;
    int used_idx[$];
    int free_idx[$];
    req_beat_t beat;
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_free[i]) free_idx.push_back(i);
      else used_idx.push_back(i);
    end
    beat.op            = OP_ALLOC;
    beat.request_size  = random_size(allow_big);
    beat.block_address = ADDR_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll >= 52 && roll < 80 && used_idx.size() > 0) begin
      beat.op            = OP_FREE;
      beat.request_size  = ADDR_W'($urandom);
      beat.block_address = user_addr(used_idx[$urandom_range(0, used_idx.size() - 1)]);
    end else if (roll >= 80 && roll < 86 && free_idx.size() > 0) begin
      beat.op            = OP_FREE;
      beat.request_size  = ADDR_W'($urandom);
      beat.block_address = user_addr(free_idx[$urandom_range(0, free_idx.size() - 1)]);
    end else if (roll >= 86 && roll < 90) begin
      beat.op            = OP_FREE;
      beat.block_address = '0;
    end else if (roll >= 90 && roll < 95) begin
      beat.op            = OP_FREE;
    end else if (roll >= 95) begin
      beat.request_size  = '0;
    end
    return beat;
  endfunction

  // Random beats in bursts of random length with random gaps between them
  task automatic send_random_bursts(input int count, input bit allow_big);
    int burst;
    burst = 0;
    while (count > 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 25));
      end
      send_request(random_request(allow_big));
      burst--;
      count--;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: receiver stall pattern and long hold-off
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int mode;
    int len;
    int hold;
    hold = 0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(5, 60);
      repeat (len) begin
        @(negedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          hold     = HOLD_CYCLES;
        end
        if (hold > 0) begin
          hold--;
          rsp_ready <= 1'b0;
        end else begin
          case (mode)
            0: begin
              rsp_ready <= 1'b1;
            end
            1: begin
              rsp_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
              rsp_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
              rsp_ready <= ~rsp_ready;
            end
          endcase
        end
      end
    end
  end

  task automatic note_mismatch(input string what, input rsp_beat_t want, input rsp_beat_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t: %s: expected address %h status %0d, got address %h status %0d",
               $realtime, what, want.address, want.status, got.address, got.status);
  endtask

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    rsp_beat_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      case (rsp.status)
        ST_OK:         n_ok++;
        ST_ZERO_SIZE:  n_zero++;
        ST_HEAP_FULL:  n_heap++;
        ST_TABLE_FULL: n_table++;
        ST_NOT_FOUND:  n_missing++;
        default: ;
      endcase
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, rsp);
      end else begin
        want = pending_results.pop_front();
        if (rsp.address !== want.address || rsp.status !== want.status)
          note_mismatch("result mismatch", want, rsp);
      end
    end
  end

  // Watchdog: too long with no beat on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Rounding, reuse, merging and the odd free cases
  task automatic test_basic_requests();
    send_request(make_req(OP_ALLOC, 20'd1, 20'hFFFFF));
    send_request(make_req(OP_ALLOC, 20'd8, 20'd0));
    send_request(make_req(OP_ALLOC, 20'd9, 20'd0));
    send_request(make_req(OP_ALLOC, 20'h3FFF9, 20'd0));
    send_request(make_req(OP_ALLOC, 20'd24, 20'd0));
    send_request(make_req(OP_ALLOC, 20'd0, 20'hFFFFF));      // zero size
    send_request(make_req(OP_FREE, 20'hFFFFF, 20'd0));       // null free
    send_request(make_req(OP_FREE, 20'd0, 20'hFFFFF));       // address not in table
    send_request(make_req(OP_FREE, 20'd0, 20'd1));
    send_request(make_req(OP_FREE, 20'd0, user_addr(1)));
    send_request(make_req(OP_FREE, 20'd0, user_addr(1)));    // double free
    send_request(make_req(OP_ALLOC, 20'd8, 20'd0));          // reuses block 1
    send_request(make_req(OP_FREE, 20'd0, user_addr(1)));
    send_request(make_req(OP_FREE, 20'd0, user_addr(2)));    // merges 1 and 2
    send_request(make_req(OP_FREE, 20'd0, user_addr(0)));    // merges 0 into the run
    send_request(make_req(OP_ALLOC, 20'd80, 20'd0));         // fits the merged block
    send_request(make_req(OP_ALLOC, 20'hFFFFF, 20'd0));      // heap full
    send_request(make_req(OP_ALLOC, 20'hFFFF9, 20'd0));
    send_request(make_req(OP_FREE, 20'd0, user_addr(tbl_count - 1)));  // trailing free block
    send_request(make_req(OP_ALLOC, 20'd40, 20'd0));
  endtask

  // Heap limit at zero, at an exact fit, at the pointer and at full size
  task automatic test_heap_limit();
    write_heap_limit('0);
    send_request(make_req(OP_ALLOC, 20'd4000, 20'd0));
    send_request(make_req(OP_ALLOC, 20'd1, 20'd0));
    write_heap_limit(model_top + LIMIT_W'(HDR) + LIMIT_W'(4000));
    send_request(make_req(OP_ALLOC, 20'd4000, 20'd0));       // exact fit
    send_request(make_req(OP_ALLOC, 20'd4000, 20'd0));       // one block too many
    write_heap_limit(model_top);
    send_request(make_req(OP_ALLOC, 20'd3000, 20'd0));
    write_heap_limit(LIMIT_RESET);
    send_request(make_req(OP_ALLOC, 20'd3000, 20'd0));
  endtask

  // Fill the table, then reuse, merge and allocate again
  task automatic test_table_full();
    while (tbl_count < MAXB)
      send_request(make_req(OP_ALLOC, ADDR_W'($urandom_range(1, 32)), ADDR_W'($urandom)));
    send_request(make_req(OP_ALLOC, 20'd60000, 20'd0));      // table full before heap
    send_request(make_req(OP_ALLOC, 20'd1, 20'd0));
    send_request(make_req(OP_FREE, 20'd0, user_addr(MAXB / 2)));
    send_request(make_req(OP_ALLOC, 20'd1, 20'd0));
    send_request(make_req(OP_FREE, 20'd0, user_addr(10)));
    send_request(make_req(OP_FREE, 20'd0, user_addr(11)));
    send_request(make_req(OP_ALLOC, 20'd64, 20'd0));
  endtask

  // Receiver holds off while the sender keeps offering, then the sender waits
  task automatic test_backpressure();
    wait_for_drain(0);
    hold_req = 1'b1;
    repeat (12) send_request(random_request(1'b0));
    wait_for_drain(0);
    repeat (6) send_request(random_request(1'b0));
  endtask

  // Random traffic over several heap limit settings
  task automatic test_random_traffic();
    write_heap_limit(LIMIT_RESET);
    send_random_bursts(120, 1'b0);
    write_heap_limit((model_top + 2047 > LIMIT_RESET) ? LIMIT_RESET :
                     model_top + LIMIT_W'($urandom_range(0, 2047)));
    send_random_bursts(80, 1'b1);
    write_heap_limit('0);
    send_random_bursts(40, 1'b1);
    write_heap_limit(LIMIT_RESET);
    send_random_bursts(120, 1'b0);
    write_heap_limit(LIMIT_W'($urandom_range(0, 1048576)));
    send_random_bursts(40, 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_heap_limit(LIMIT_RESET);

    test_basic_requests();
    test_heap_limit();
    test_table_full();
    test_backpressure();
    test_random_traffic();

    wait_for_drain(SETTLE_CYCLES);

    $display("Sent %0d requests: %0d ok, %0d zero size, %0d heap full, %0d table full,",
             n_sent, n_ok, n_zero, n_heap, n_table);
    $display("%0d unknown frees, %0d merges; %0d mismatches", n_missing, n_merges, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
